// ===== hw/rtl/tts_pkg.sv =====
// Shared types and constants for the thread table scheduler.
// No dependencies; imported by tts_ctrl, tts_datapath and thread_table_scheduler.
package tts_pkg;

    localparam int NUM_THREADS_DEF = 8;
    localparam int FUNC_W          = 2;
    localparam int SLOT_W          = 3;
    localparam int STATUS_W        = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_CREATE = 2'd0,
        FN_YIELD  = 2'd1,
        FN_EXIT   = 2'd2,
        FN_JOIN   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        SL_INVALID  = 2'd0,
        SL_ACTIVE   = 2'd1,
        SL_BLOCKED  = 2'd2,
        SL_FINISHED = 2'd3
    } slot_state_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK       = 2'd0,
        STS_FULL     = 2'd1,
        STS_BAD_JOIN = 2'd2,
        STS_NO_RUN   = 2'd3
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_scan;
        logic scan_done;
        logic out_free;
    } dp_sts_t;

endpackage

// ===== hw/rtl/tts_ctrl.sv =====
// Command sequencer for the thread table scheduler: idle / scan / done.
// Depends on tts_pkg; drives tts_datapath through dp_cmd_t.
module tts_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output tts_pkg::dp_cmd_t  cmd,
    input  tts_pkg::dp_sts_t  sts
);
    import tts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.need_scan ? S_SCAN : S_DONE;
                end
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // wait here while the previous result is still held
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid) |=> (state_reg != S_IDLE))
        else $error("controller stayed idle after a transfer");
`endif

endmodule

// ===== hw/rtl/tts_datapath.sv =====
// Thread slot table, current-thread register, slot scan counter and result register.
// Depends on tts_pkg; sequenced by tts_ctrl.
module tts_datapath
#(
    parameter int NUM_THREADS = tts_pkg::NUM_THREADS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  tts_pkg::dp_cmd_t              cmd,
    output tts_pkg::dp_sts_t              sts,
    input  logic [tts_pkg::FUNC_W-1:0]    func,
    input  logic [tts_pkg::SLOT_W-1:0]    target,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tts_pkg::SLOT_W-1:0]    running_thread,
    output logic                          running_valid,
    output logic [tts_pkg::SLOT_W-1:0]    created_thread,
    output logic [tts_pkg::STATUS_W-1:0]  status
);
    import tts_pkg::*;

    localparam int IW = $clog2(NUM_THREADS);
    localparam int CW = $clog2(NUM_THREADS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_THREADS - 1);

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    // thread table
    slot_state_t            slot_state_reg  [NUM_THREADS];
    slot_state_t            slot_state_next [NUM_THREADS];
    logic [NUM_THREADS-1:0] joiner_valid_reg;
    logic [NUM_THREADS-1:0] joiner_valid_next;
    logic [IW-1:0]          joiner_slot_reg  [NUM_THREADS];
    logic [IW-1:0]          joiner_slot_next [NUM_THREADS];
    logic [IW-1:0]          cur_slot_reg;
    logic [IW-1:0]          cur_slot_next;
    logic                   cur_valid_reg;
    logic                   cur_valid_next;

    // latched command and scan state
    func_t                  func_reg;
    func_t                  func_next;
    logic [SLOT_W-1:0]      target_reg;
    logic [SLOT_W-1:0]      target_next;
    slot_state_t            want_reg;
    slot_state_t            want_next;
    logic [IW-1:0]          scan_idx_reg;
    logic [IW-1:0]          scan_idx_next;
    logic [CW-1:0]          scan_left_reg;
    logic [CW-1:0]          scan_left_next;
    logic                   found_reg;
    logic                   found_next;
    logic [IW-1:0]          found_idx_reg;
    logic [IW-1:0]          found_idx_next;

    // result register
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [SLOT_W-1:0]      running_thread_reg;
    logic [SLOT_W-1:0]      running_thread_next;
    logic                   running_valid_reg;
    logic                   running_valid_next;
    logic [SLOT_W-1:0]      created_reg;
    logic [SLOT_W-1:0]      created_next;
    status_t                status_reg;
    status_t                status_next;

    func_t                  func_in;
    logic                   match;
    logic [IW-1:0]          tgt_idx;
    logic                   tgt_in_range;
    logic [IW-1:0]          jn_idx;

    assign func_in      = func_t'(func);
    assign match        = (slot_state_reg[scan_idx_reg] == want_reg);
    assign tgt_idx      = IW'(target_reg);
    assign tgt_in_range = (int'(target_reg) < NUM_THREADS);
    assign jn_idx       = joiner_slot_reg[cur_slot_reg];

    always_comb
    begin
        sts.out_free  = !out_valid_reg || !out_stall;
        sts.scan_done = match || (scan_left_reg == CW'(1));
        case (func_in)
            FN_CREATE: sts.need_scan = 1'b1;
            FN_YIELD:  sts.need_scan = 1'b1;
            FN_EXIT:   sts.need_scan = cur_valid_reg && !joiner_valid_reg[cur_slot_reg];
            default:   sts.need_scan = 1'b0;
        endcase
    end

    // command latch and slot scan, one slot per cycle
    always_comb
    begin
        func_next      = func_reg;
        target_next    = target_reg;
        want_next      = want_reg;
        scan_idx_next  = scan_idx_reg;
        scan_left_next = scan_left_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        if (cmd.load)
        begin
            func_next   = func_in;
            target_next = target;
            want_next   = (func_in == FN_CREATE) ? SL_INVALID : SL_ACTIVE;
            found_next  = 1'b0;
            // yield/exit skip the running slot itself
            if (func_in != FN_CREATE && cur_valid_reg)
            begin
                scan_idx_next  = wrap_inc(cur_slot_reg);
                scan_left_next = CW'(NUM_THREADS - 1);
            end
            else
            begin
                scan_idx_next  = '0;
                scan_left_next = CW'(NUM_THREADS);
            end
        end
        else if (cmd.step)
        begin
            if (match && !found_reg)
            begin
                found_next     = 1'b1;
                found_idx_next = scan_idx_reg;
            end
            scan_idx_next  = wrap_inc(scan_idx_reg);
            scan_left_next = scan_left_reg - 1'b1;
        end
    end

    // table update and result on commit
    always_comb
    begin
        slot_state_next   = slot_state_reg;
        joiner_valid_next = joiner_valid_reg;
        joiner_slot_next  = joiner_slot_reg;
        cur_slot_next     = cur_slot_reg;
        cur_valid_next    = cur_valid_reg;
        created_next      = '0;
        status_next       = STS_OK;
        if (cmd.commit)
        begin
            case (func_reg)
                FN_CREATE:
                begin
                    if (!found_reg)
                    begin
                        status_next = STS_FULL;
                    end
                    else
                    begin
                        slot_state_next[found_idx_reg]   = SL_ACTIVE;
                        joiner_valid_next[found_idx_reg] = 1'b0;
                        joiner_slot_next[found_idx_reg]  = '0;
                        created_next                     = SLOT_W'(found_idx_reg);
                        if (!cur_valid_reg)
                        begin
                            cur_slot_next  = found_idx_reg;
                            cur_valid_next = 1'b1;
                        end
                    end
                end
                FN_YIELD:
                begin
                    if (found_reg)
                    begin
                        cur_slot_next  = found_idx_reg;
                        cur_valid_next = 1'b1;
                    end
                    else if (!cur_valid_reg)
                    begin
                        status_next = STS_NO_RUN;
                    end
                end
                FN_EXIT:
                begin
                    if (!cur_valid_reg)
                    begin
                        status_next = STS_NO_RUN;
                    end
                    else
                    begin
                        slot_state_next[cur_slot_reg] = SL_FINISHED;
                        if (joiner_valid_reg[cur_slot_reg])
                        begin
                            joiner_valid_next[cur_slot_reg] = 1'b0;
                            slot_state_next[jn_idx]         = SL_ACTIVE;
                            cur_slot_next                   = jn_idx;
                        end
                        else if (found_reg)
                        begin
                            cur_slot_next = found_idx_reg;
                        end
                        else
                        begin
                            cur_valid_next = 1'b0;
                            cur_slot_next  = '0;
                            status_next    = STS_NO_RUN;
                        end
                    end
                end
                FN_JOIN:
                begin
                    if (!cur_valid_reg)
                    begin
                        status_next = STS_NO_RUN;
                    end
                    else if (!tgt_in_range || tgt_idx == cur_slot_reg)
                    begin
                        status_next = STS_BAD_JOIN;
                    end
                    else if (slot_state_reg[tgt_idx] == SL_FINISHED)
                    begin
                        status_next = STS_OK;
                    end
                    else if (slot_state_reg[tgt_idx] != SL_ACTIVE || joiner_valid_reg[tgt_idx])
                    begin
                        status_next = STS_BAD_JOIN;
                    end
                    else
                    begin
                        slot_state_next[cur_slot_reg] = SL_BLOCKED;
                        joiner_valid_next[tgt_idx]    = 1'b1;
                        joiner_slot_next[tgt_idx]     = cur_slot_reg;
                        cur_slot_next                 = tgt_idx;
                    end
                end
                default:
                begin
                    status_next = STS_OK;
                end
            endcase
        end
        running_valid_next  = cur_valid_next;
        running_thread_next = cur_valid_next ? SLOT_W'(cur_slot_next) : '0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_THREADS; i++)
            begin
                slot_state_reg[i]  <= (i == 0) ? SL_ACTIVE : SL_INVALID;
                joiner_slot_reg[i] <= '0;
            end
            joiner_valid_reg <= '0;
            cur_slot_reg     <= '0;
            cur_valid_reg    <= 1'b1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            slot_state_reg   <= slot_state_next;
            joiner_slot_reg  <= joiner_slot_next;
            joiner_valid_reg <= joiner_valid_next;
            cur_slot_reg     <= cur_slot_next;
            cur_valid_reg    <= cur_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        target_reg    <= target_next;
        want_reg      <= want_next;
        scan_idx_reg  <= scan_idx_next;
        scan_left_reg <= scan_left_next;
        found_reg     <= found_next;
        found_idx_reg <= found_idx_next;
        if (cmd.commit)
        begin
            running_thread_reg <= running_thread_next;
            running_valid_reg  <= running_valid_next;
            created_reg        <= created_next;
            status_reg         <= status_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign running_thread = running_thread_reg;
    assign running_valid  = running_valid_reg;
    assign created_thread = created_reg;
    assign status         = status_reg;

`ifndef SYNTH
    a_current_is_active: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (slot_state_reg[cur_slot_reg] == SL_ACTIVE))
        else $error("current thread is not in the active state");

    a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && out_stall))
        else $error("result overwritten while held");

    a_full_no_create: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == STS_FULL) |-> (created_reg == '0))
        else $error("failed create reports a slot");
`endif

endmodule

// ===== hw/rtl/thread_table_scheduler.sv =====
// Top level of the thread table scheduler: controller plus table datapath.
// Depends on tts_pkg, tts_ctrl and tts_datapath.
//
//   channel   direction   handshake            payload
//   in        into block  in_valid / in_stall  func, target
//   out       from block  out_valid / out_stall running_thread, running_valid,
//                                              created_thread, status
//
// Join, and exit with a joiner or with nothing running, go from the idle state straight to done, with no scan.
// Create, yield and exit without a joiner also run the slot scan counter,
// one slot a cycle, ending at the first hit or after the last slot it covers.
// Reset leaves slot 0 active and running, all other slots invalid.
// The result sits in an output register; the next command is taken while it
// waits, but its own result holds in the done state until out_stall drops.
module thread_table_scheduler
#(
    parameter int NUM_THREADS = tts_pkg::NUM_THREADS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tts_pkg::FUNC_W-1:0]    func,
    input  logic [tts_pkg::SLOT_W-1:0]    target,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tts_pkg::SLOT_W-1:0]    running_thread,
    output logic                          running_valid,
    output logic [tts_pkg::SLOT_W-1:0]    created_thread,
    output logic [tts_pkg::STATUS_W-1:0]  status
);
    import tts_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    tts_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    tts_datapath #(
        .NUM_THREADS (NUM_THREADS)
    ) u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .func           (func),
        .target         (target),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .running_thread (running_thread),
        .running_valid  (running_valid),
        .created_thread (created_thread),
        .status         (status)
    );

endmodule

// ===== verif/tb_thread_table_scheduler.sv =====
// Self-checking testbench for thread_table_scheduler: directed and random scheduling commands.
// It predicts every result from its own model of the thread table and checks each output transfer.
// Depends on tts_pkg and the thread_table_scheduler RTL.
module tb_thread_table_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    import tts_pkg::*;

    localparam int NT           = NUM_THREADS_DEF;
    localparam int RANDOM_CMDS  = 1625;
    localparam int QUIET_TAIL   = 150;
    localparam int DRAIN_CYCLES = 3 * (NT + 2);
    localparam int HANG_LIMIT   = 1000;

    typedef struct {
        func_t             op;
        logic [SLOT_W-1:0] tgt;
    } sched_cmd_t;

    typedef struct {
        logic [SLOT_W-1:0] running_thread;
        logic              running_valid;
        logic [SLOT_W-1:0] created_thread;
        status_t           status;
    } sched_out_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [FUNC_W-1:0]   func = FN_CREATE;
    logic [SLOT_W-1:0]   target = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [SLOT_W-1:0]   running_thread;
    logic                running_valid;
    logic [SLOT_W-1:0]   created_thread;
    logic [STATUS_W-1:0] status;

    // model of the thread table
    slot_state_t       tbl_state [NT];
    logic              join_ok   [NT];
    logic [SLOT_W-1:0] join_slot [NT];
    logic [SLOT_W-1:0] cur_slot;
    logic              cur_ok;

    sched_cmd_t sched_cmds_q[$];
    sched_out_t sched_results_q[$];

    bit cmd_accepted = 1'b0;
    int fails = 0;
    int in_gap = 0;
    int stall_left = 0;
    int idle_pct = 25;
    int idle_cycles = 0;
    bit calm;

    thread_table_scheduler dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .target         (target),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .running_thread (running_thread),
        .running_valid  (running_valid),
        .created_thread (created_thread),
        .status         (status)
    );

    always #1 clk = ~clk;

    assign calm = (sched_cmds_q.size() < QUIET_TAIL);

    // first active slot among n slots from start, wrapping; -1 if none
    function automatic int find_active(int start, int n);
        int hit;
        hit = -1;
        for (int k = 0; k < n; k++)
        begin
            if (hit < 0 && tbl_state[(start + k) % NT] == SL_ACTIVE)
                hit = (start + k) % NT;
        end
        return hit;
    endfunction

    function automatic sched_out_t apply_sched_cmd(sched_cmd_t c);
        sched_out_t r;
        int hit;
        logic [SLOT_W-1:0] cur;
        logic [SLOT_W-1:0] j;
        r.created_thread = '0;
        r.status = STS_OK;
        case (c.op)
            FN_CREATE:
            begin
                hit = -1;
                for (int i = 0; i < NT; i++)
                begin
                    if (hit < 0 && tbl_state[i] == SL_INVALID)
                        hit = i;
                end
                if (hit < 0)
                    r.status = STS_FULL;
                else
                begin
                    tbl_state[hit] = SL_ACTIVE;
                    join_ok[hit] = 1'b0;
                    join_slot[hit] = '0;
                    r.created_thread = hit[SLOT_W-1:0];
                    if (!cur_ok)
                    begin
                        cur_slot = hit[SLOT_W-1:0];
                        cur_ok = 1'b1;
                    end
                end
            end
            FN_YIELD:
            begin
                if (cur_ok)
                begin
                    hit = find_active(int'(cur_slot) + 1, NT - 1);
                    if (hit >= 0)
                        cur_slot = hit[SLOT_W-1:0];
                end
                else
                begin
                    hit = find_active(0, NT);
                    if (hit >= 0)
                    begin
                        cur_slot = hit[SLOT_W-1:0];
                        cur_ok = 1'b1;
                    end
                    else
                        r.status = STS_NO_RUN;
                end
            end
            FN_EXIT:
            begin
                if (!cur_ok)
                    r.status = STS_NO_RUN;
                else
                begin
                    cur = cur_slot;
                    tbl_state[cur] = SL_FINISHED;
                    if (join_ok[cur])
                    begin
                        j = join_slot[cur];
                        join_ok[cur] = 1'b0;
                        tbl_state[j] = SL_ACTIVE;
                        cur_slot = j;
                    end
                    else
                    begin
                        hit = find_active(int'(cur) + 1, NT);
                        if (hit >= 0)
                            cur_slot = hit[SLOT_W-1:0];
                        else
                        begin
                            cur_ok = 1'b0;
                            cur_slot = '0;
                            r.status = STS_NO_RUN;
                        end
                    end
                end
            end
            default:
            begin
                if (!cur_ok)
                    r.status = STS_NO_RUN;
                else if (int'(c.tgt) >= NT || c.tgt == cur_slot)
                    r.status = STS_BAD_JOIN;
                else if (tbl_state[c.tgt] == SL_FINISHED)
                    r.status = STS_OK;
                else if (tbl_state[c.tgt] != SL_ACTIVE || join_ok[c.tgt])
                    r.status = STS_BAD_JOIN;
                else
                begin
                    tbl_state[cur_slot] = SL_BLOCKED;
                    join_ok[c.tgt] = 1'b1;
                    join_slot[c.tgt] = cur_slot;
                    cur_slot = c.tgt;
                end
            end
        endcase
        r.running_thread = cur_ok ? cur_slot : '0;
        r.running_valid = cur_ok;
        return r;
    endfunction

    task automatic add_cmd(func_t op, int tgt);
        sched_cmd_t c;
        c.op = op;
        c.tgt = tgt[SLOT_W-1:0];
        sched_cmds_q.push_back(c);
    endtask

    // driver: new command only after the previous one transferred
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || cmd_accepted))
        begin
            if (in_gap == 0 && !calm && $urandom_range(0, 99) < idle_pct)
                in_gap = $urandom_range(1, 6);
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (sched_cmds_q.size() != 0)
            begin
                if (sched_cmds_q.size() % 97 == 0)
                    idle_pct = $urandom_range(0, 2) * 25;
                func <= sched_cmds_q[0].op;
                target <= sched_cmds_q[0].tgt;
                in_valid <= 1'b1;
                void'(sched_cmds_q.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 99) < idle_pct)
            begin
                stall_left = $urandom_range(1, 6) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // monitor: check result transfers, predict on command transfers
    always @(posedge clk)
    begin
        sched_out_t exp_r;
        sched_cmd_t c;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (sched_results_q.size() == 0)
                begin
                    $error("result transfer with no command pending");
                    fails++;
                end
                else
                begin
                    exp_r = sched_results_q.pop_front();
                    if (running_thread !== exp_r.running_thread)
                    begin
                        $error("running_thread: expected %0d, got %0d",
                               exp_r.running_thread, running_thread);
                        fails++;
                    end
                    if (running_valid !== exp_r.running_valid)
                    begin
                        $error("running_valid: expected %0d, got %0d",
                               exp_r.running_valid, running_valid);
                        fails++;
                    end
                    if (created_thread !== exp_r.created_thread)
                    begin
                        $error("created_thread: expected %0d, got %0d",
                               exp_r.created_thread, created_thread);
                        fails++;
                    end
                    if (status !== exp_r.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_r.status, status);
                        fails++;
                    end
                end
            end
            cmd_accepted = in_valid && !in_stall;
            if (cmd_accepted)
            begin
                c.op = func_t'(func);
                c.tgt = target;
                sched_results_q.push_back(apply_sched_cmd(c));
            end
        end
    end

    // hang detector: nothing transferred on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= HANG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int r;
        for (int i = 0; i < NT; i++)
        begin
            tbl_state[i] = SL_INVALID;
            join_ok[i] = 1'b0;
            join_slot[i] = '0;
        end
        tbl_state[0] = SL_ACTIVE;
        cur_slot = '0;
        cur_ok = 1'b1;

        // lone thread: yield keeps it, self and invalid joins rejected
        add_cmd(FN_YIELD, 0);
        add_cmd(FN_JOIN, 0);
        add_cmd(FN_JOIN, 5);
        // last thread exits, then nothing can run
        add_cmd(FN_EXIT, 0);
        add_cmd(FN_YIELD, 7);
        add_cmd(FN_EXIT, 0);
        add_cmd(FN_JOIN, 2);
        // create with nobody running takes over
        add_cmd(FN_CREATE, 0);
        add_cmd(FN_CREATE, 7);
        add_cmd(FN_CREATE, 0);
        add_cmd(FN_JOIN, 0);     // finished target returns at once
        add_cmd(FN_YIELD, 0);
        add_cmd(FN_JOIN, 1);
        add_cmd(FN_JOIN, 2);     // blocked target
        add_cmd(FN_YIELD, 0);
        add_cmd(FN_JOIN, 1);     // target already has a joiner
        add_cmd(FN_EXIT, 0);     // no joiner: round-robin
        add_cmd(FN_EXIT, 0);     // joiner resumes
        for (int i = 0; i < 5; i++)
            add_cmd(FN_CREATE, 0);   // fills the table, last one full
        add_cmd(FN_JOIN, 7);
        add_cmd(FN_YIELD, 0);

        // exits are kept rare so live threads last most of the run
        for (int i = 0; i < RANDOM_CMDS; i++)
        begin
            r = $urandom_range(0, 199);
            if (r == 0)
                add_cmd(FN_EXIT, $urandom_range(0, 7));
            else if (r <= 12)
                add_cmd(FN_CREATE, $urandom_range(0, 7));
            else if (r <= 90)
                add_cmd(FN_YIELD, $urandom_range(0, 7));
            else
                add_cmd(FN_JOIN, $urandom_range(0, 7));
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (sched_cmds_q.size() != 0 || in_valid)
            @(posedge clk);
        while (sched_results_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
